// ----- rtl/bols_pkg.sv -----
// Shared types and constants of the bounded ordered list store.
package bols_pkg;

   localparam int ACTION_W      = 3;
   localparam int VALUE_W       = 32;
   localparam int COUNT_FIELD_W = 5;
   localparam int STATUS_W      = 2;
   localparam int MAX_RESULTS   = 16;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_LIST       = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  value_out;
      logic                       last;
      logic [COUNT_FIELD_W-1:0]   count;
      logic [STATUS_W-1:0]        status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP,
      OP_MARK,
      OP_COMPACT,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_COMPACT,
      CTRL_LIST
   } ctrl_state_type;

endpackage

// ----- rtl/bols_cell.sv -----
// One storage cell of the list chain: holds one entry and its keep mark.
module bols_cell #(
   parameter int CAPACITY = 16,
   parameter int INDEX    = 0,
   localparam int COUNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bols_pkg::cell_cmd_type              cmd,
   input  logic [COUNT_W-1:0]                  count,
   input  logic signed [bols_pkg::VALUE_W-1:0] left_data,
   input  logic signed [bols_pkg::VALUE_W-1:0] right_data,
   input  logic signed [bols_pkg::VALUE_W-1:0] head_data,
   input  logic                                left_keep,
   input  logic                                right_keep,
   output logic signed [bols_pkg::VALUE_W-1:0] data,
   output logic                                keep,
   output logic                                match,
   output logic                                pair
);
   import bols_pkg::*;

   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic                      keep_ff, keep_in;
   logic                      in_list, at_tail, next_in_list, next_at_tail;

   assign in_list      = COUNT_W'(INDEX) < count;
   assign at_tail      = COUNT_W'(INDEX) == count;
   assign next_in_list = COUNT_W'(INDEX + 1) < count;
   assign next_at_tail = COUNT_W'(INDEX + 1) == count;

   always_comb begin
      data_in = data_ff;
      keep_in = keep_ff;
      case (cmd.op)
         OP_PUSH_FRONT: begin
            data_in = (INDEX == 0) ? cmd.value : left_data;
         end
         OP_PUSH_BACK: begin
            if (at_tail) begin
               data_in = cmd.value;
            end
         end
         OP_POP: begin
            data_in = right_data;
         end
         OP_MARK: begin
            // the head survives: this pass runs only when it did not match
            keep_in = (INDEX == 0) || (in_list && (data_ff != cmd.value));
         end
         OP_COMPACT: begin
            // a hole takes the survivor on its right; that survivor becomes a hole
            if (!keep_ff && right_keep) begin
               data_in = right_data;
               keep_in = 1'b1;
            end else if ((INDEX != 0) && keep_ff && !left_keep) begin
               keep_in = 1'b0;
            end
         end
         OP_ROTATE: begin
            // rotate the occupied part left; the tail takes the head
            if (next_in_list) begin
               data_in = right_data;
            end else if (next_at_tail) begin
               data_in = head_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         keep_ff <= 1'b0;
      end else begin
         keep_ff <= keep_in;
      end
   end

   assign data  = data_ff;
   assign keep  = keep_ff;
   assign match = in_list && (data_ff == cmd.value);
   assign pair  = !keep_ff && right_keep;

endmodule

// ----- rtl/bols_ctrl.sv -----
// Sequencer of the list store: decodes actions, drives the cell chain, forms results.
module bols_ctrl #(
   parameter int CAPACITY = 16,
   localparam int COUNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   input  bols_pkg::req_payload_type           req_payload,
   output logic                                busy,
   output logic                                rsp_strobe,
   output bols_pkg::rsp_payload_type           rsp_payload,
   output bols_pkg::cell_cmd_type              cmd,
   output logic [COUNT_W-1:0]                  count,
   input  logic signed [bols_pkg::VALUE_W-1:0] head_data,
   input  logic [CAPACITY-1:0]                 keep_vec,
   input  logic [CAPACITY-1:0]                 match_vec,
   input  logic [CAPACITY-1:0]                 pair_vec
);
   import bols_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              accept, full, empty, head_hit, later_hit;
   logic [COUNT_W-1:0] packed_count;
   logic [CAPACITY:0] keep_ext;

   assign accept    = req_start && (state_ff == CTRL_IDLE);
   assign full      = count_ff == COUNT_W'(CAPACITY);
   assign empty     = count_ff == '0;
   assign head_hit  = match_vec[0];
   assign later_hit = |match_vec[CAPACITY-1:1];
   assign keep_ext  = {1'b0, keep_vec};

   // survivors sit at the front once compaction ends: the count is the boundary
   always_comb begin
      packed_count = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (keep_ext[i] && !keep_ext[i+1]) begin
            packed_count = packed_count | COUNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_strobe_in = 1'b0;
      cmd.op        = OP_HOLD;
      cmd.value     = req_payload.value;
      rsp_in        = rsp_ff;
      rsp_in.value_out = '0;
      rsp_in.last      = 1'b1;
      rsp_in.status    = ST_OK;
      case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               case (req_payload.action)
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        cmd.op   = (req_payload.action == ACT_PUSH_FRONT) ?
                                   OP_PUSH_FRONT : OP_PUSH_BACK;
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        cmd.op   = OP_POP;
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  ACT_CLEAR: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end
                     count_in = '0;
                  end
                  ACT_REMOVE: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (head_hit) begin
                        cmd.op   = OP_POP;
                        count_in = count_ff - COUNT_W'(1);
                     end else begin
                        cmd.op = OP_MARK;
                        if (later_hit) begin
                           rsp_strobe_in = 1'b0;
                           state_in      = CTRL_COMPACT;
                        end else begin
                           rsp_in.status = ST_NOT_FOUND;
                        end
                     end
                  end
                  ACT_LIST: begin
                     if (empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        step_in       = '0;
                        state_in      = CTRL_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CTRL_COMPACT: begin
            if (|pair_vec) begin
               cmd.op = OP_COMPACT;
            end else begin
               count_in      = packed_count;
               rsp_strobe_in = 1'b1;
               state_in      = CTRL_IDLE;
            end
         end
         CTRL_LIST: begin
            // emit the head each cycle, up to MAX_RESULTS beats; a full turn restores the order
            cmd.op  = OP_ROTATE;
            step_in = step_ff + COUNT_W'(1);
            if (int'(step_ff) < MAX_RESULTS) begin
               rsp_strobe_in    = 1'b1;
               rsp_in.value_out = head_data;
               rsp_in.last      = (step_in == count_ff) || (int'(step_ff) == MAX_RESULTS - 1);
            end
            if (step_in == count_ff) begin
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
      rsp_in.count = COUNT_FIELD_W'(count_in);
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff      <= CTRL_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy        = state_ff != CTRL_IDLE;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
   assign count       = count_ff;

endmodule

// ----- rtl/bounded_ordered_list_store_unit.sv -----
// Push, pop, clear, remove of the head or a miss, and unused codes answer
// in the cycle after the beat is taken and leave busy low.
// Remove of later entries: a mark step, then compaction rounds that swap each hole with
// the survivor on its right until no pair is left, then the result; busy is high meanwhile.
// List: one result beat per cycle from the chain head, up to MAX_RESULTS beats; busy while the chain rotates.
// Reset (synchronous): empties the list and the sequencer; entries keep stale data.
module bounded_ordered_list_store_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  bols_pkg::req_payload_type req_payload,
   output logic                      busy,
   output logic                      rsp_strobe,
   output bols_pkg::rsp_payload_type rsp_payload
);
   import bols_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   cell_cmd_type              cmd;
   logic [COUNT_W-1:0]        count;
   logic signed [VALUE_W-1:0] data_w [CAPACITY];
   logic [CAPACITY-1:0]       keep_w, match_w, pair_w;

   bols_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .count       (count),
      .head_data   (data_w[0]),
      .keep_vec    (keep_w),
      .match_vec   (match_w),
      .pair_vec    (pair_w)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

      bols_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .count      (count),
         .left_data  (data_w[LEFT]),
         .right_data (data_w[RIGHT]),
         .head_data  (data_w[0]),
         .left_keep  (keep_w[LEFT]),
         .right_keep ((i == CAPACITY - 1) ? 1'b0 : keep_w[RIGHT]),
         .data       (data_w[i]),
         .keep       (keep_w[i]),
         .match      (match_w[i]),
         .pair       (pair_w[i])
      );
   end

endmodule

// ----- rtl/bols_checker.sv -----
// Port-level checks of the list store, bound to the top level.
module bols_checker #(
   parameter int CAPACITY = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_start,
   input bols_pkg::req_payload_type req_payload,
   input logic                      busy,
   input logic                      rsp_strobe,
   input bols_pkg::rsp_payload_type rsp_payload
);
   import bols_pkg::*;

   // a full flag means the list really holds CAPACITY entries
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status == ST_FULL)
      |-> rsp_payload.count == COUNT_FIELD_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (CAPACITY > 31) || (int'(rsp_payload.count) <= CAPACITY))
      else $error("count beyond capacity");

   // single-beat actions answer on the next cycle
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy && (req_payload.action != ACT_LIST)
      && (req_payload.action != ACT_REMOVE)
      |=> rsp_strobe && rsp_payload.last)
      else $error("single-beat action did not answer");

   // listing beats come back to back until the last one
   a_list_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |=> rsp_strobe)
      else $error("gap inside a listing burst");

   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.value_out != '0) |-> rsp_payload.status == ST_OK)
      else $error("value on a non-ok result");

endmodule

bind bounded_ordered_list_store_unit bols_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

// ----- tb/bounded_ordered_list_store_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the ordered list store: directed and random actions against a shadow list.
module bounded_ordered_list_store_unit_tb;
   import bols_pkg::*;

   localparam int LIST_CAPACITY = 16;
   localparam int DRAIN_CYCLES  = 2 * LIST_CAPACITY + 8;

   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_start   = 1'b0;
   req_payload_type req_payload = '0;
   logic            busy;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;

   logic signed [VALUE_W-1:0] shadow_list[$];
   rsp_payload_type           awaited_answers[$];
   int unsigned               error_count  = 0;
   int unsigned               idle_percent = 0;

   bounded_ordered_list_store_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_payload(req_payload),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic rsp_payload_type make_answer(input logic signed [VALUE_W-1:0] v,
                                                   input logic last,
                                                   input logic [STATUS_W-1:0] st);
      rsp_payload_type a;
      int              n;
      n = shadow_list.size();
      a.value_out = v;
      a.last      = last;
      a.count     = n[COUNT_FIELD_W-1:0];
      a.status    = st;
      return a;
   endfunction

   // Apply one accepted action to the shadow list and queue the answers it causes.
   function automatic void apply_action(input req_payload_type item);
      logic [STATUS_W-1:0] st;
      logic                hit;
      int                  n;
      int                  i;
      st  = ST_OK;
      hit = 1'b0;
      case (item.action)
         ACT_PUSH_FRONT: begin
            if (shadow_list.size() >= LIST_CAPACITY) st = ST_FULL;
            else shadow_list.push_front(item.value);
         end
         ACT_PUSH_BACK: begin
            if (shadow_list.size() >= LIST_CAPACITY) st = ST_FULL;
            else shadow_list.push_back(item.value);
         end
         ACT_POP_FRONT: begin
            if (shadow_list.size() == 0) st = ST_EMPTY;
            else void'(shadow_list.pop_front());
         end
         ACT_CLEAR: begin
            if (shadow_list.size() == 0) st = ST_EMPTY;
            shadow_list.delete();
         end
         ACT_REMOVE: begin
            if (shadow_list.size() == 0) begin
               st = ST_EMPTY;
            end else if (shadow_list[0] == item.value) begin
               // head match takes the head only; later copies stay
               void'(shadow_list.pop_front());
            end else begin
               for (i = shadow_list.size() - 1; i >= 1; i--) begin
                  if (shadow_list[i] == item.value) begin
                     shadow_list.delete(i);
                     hit = 1'b1;
                  end
               end
               if (!hit) st = ST_NOT_FOUND;
            end
         end
         ACT_LIST: begin
            if (shadow_list.size() == 0) begin
               st = ST_EMPTY;
            end else begin
               n = (shadow_list.size() < MAX_RESULTS) ? shadow_list.size() : MAX_RESULTS;
               for (i = 0; i < n; i++)
                  awaited_answers.push_back(make_answer(shadow_list[i], i == n - 1, ST_OK));
               return;
            end
         end
         default: ;
      endcase
      awaited_answers.push_back(make_answer('0, 1'b1, st));
   endfunction

   // Present one beat, hold until taken, then idle at random.
   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic signed [VALUE_W-1:0] value);
      req_payload_type item;
      item.action = action;
      item.value  = value;
      req_payload <= item;
      req_start   <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      apply_action(item);
      while ($urandom_range(0, 99) < idle_percent) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic stop_sending();
      req_start <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : check_answers
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat, value_out %0d count %0d",
                                         rsp_payload.value_out, rsp_payload.count));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_payload.value_out !== want.value_out)
                  report_mismatch($sformatf("value_out %0d, expected %0d",
                                            rsp_payload.value_out, want.value_out));
               if (rsp_payload.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_payload.last, want.last));
               if (rsp_payload.count !== want.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_payload.count, want.count));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, want.status));
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("rsp_strobe unknown");
         end
      end
   end

   function automatic logic signed [VALUE_W-1:0] choose_operand();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3, 4: return $signed($urandom_range(0, 4)) - 2;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_list_actions();
      send_item(ACT_LIST, 0);
      send_item(ACT_POP_FRONT, 0);
      send_item(ACT_CLEAR, 0);
      send_item(ACT_REMOVE, 5);
      send_item(ACT_SPARE_6, VALUE_MAX);
      send_item(ACT_SPARE_7, VALUE_MIN);
      stop_sending();
   endtask

   task automatic test_fill_to_capacity();
      send_item(ACT_PUSH_BACK, VALUE_MIN);
      send_item(ACT_PUSH_BACK, VALUE_MAX);
      send_item(ACT_PUSH_BACK, 0);
      send_item(ACT_PUSH_BACK, -1);
      send_item(ACT_PUSH_BACK, 7);
      send_item(ACT_PUSH_BACK, 3);
      send_item(ACT_PUSH_BACK, 7);
      send_item(ACT_PUSH_BACK, 1);
      send_item(ACT_PUSH_BACK, 7);
      send_item(ACT_PUSH_BACK, -2);
      send_item(ACT_PUSH_BACK, 32'sh5555_5555);
      send_item(ACT_PUSH_BACK, 32'shAAAA_AAAA);
      send_item(ACT_PUSH_BACK, 7);
      send_item(ACT_PUSH_BACK, 2);
      send_item(ACT_PUSH_FRONT, 3);
      send_item(ACT_PUSH_BACK, 7);
      // list is full now: both pushes drop
      send_item(ACT_PUSH_FRONT, 9);
      send_item(ACT_PUSH_BACK, 9);
      send_item(ACT_LIST, 0);
      stop_sending();
   endtask

   task automatic test_remove_by_value();
      send_item(ACT_REMOVE, 3);
      send_item(ACT_REMOVE, 7);
      send_item(ACT_REMOVE, 12345);
      send_item(ACT_POP_FRONT, 0);
      send_item(ACT_LIST, 0);
      stop_sending();
   endtask

   task automatic run_random_actions(input int unsigned n_items, input int unsigned pct);
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
      int unsigned               pick;
      idle_percent = pct;
      repeat (n_items) begin
         pick  = $urandom_range(0, 99);
         value = choose_operand();
         if (pick < 30)      action = ACT_PUSH_FRONT;
         else if (pick < 60) action = ACT_PUSH_BACK;
         else if (pick < 68) action = ACT_POP_FRONT;
         else if (pick < 71) action = ACT_CLEAR;
         else if (pick < 86) action = ACT_REMOVE;
         else if (pick < 97) action = ACT_LIST;
         else                action = pick[0] ? ACT_SPARE_7 : ACT_SPARE_6;
         // aim most removes at a stored value so they hit
         if (action == ACT_REMOVE && shadow_list.size() != 0 && $urandom_range(0, 9) < 7)
            value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
         send_item(action, value);
      end
      stop_sending();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_percent = 13;
      test_empty_list_actions();
      test_fill_to_capacity();
      test_remove_by_value();
      run_random_actions(117, 13);
      run_random_actions(117, 83);
      run_random_actions(116, 0);
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
